// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Implication or plain property checked on every clock edge out of reset.
`define ATFB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never be true out of reset.
`define ATFB_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ATFB_ASSERT(label, clk, rst_n, prop, msg)
`define ATFB_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/atfb_pkg.sv =====
// ---------------------------------------------------------------------------
// atfb_pkg
// Types, codes and constants of the API transmit frame builder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package atfb_pkg;

  // Frame constants.
  localparam logic [7:0] FRAME_START  = 8'h7E;
  localparam logic [7:0] API_TX16     = 8'h01;
  localparam logic [8:0] LEN_OVERHEAD = 9'd5;

  // Register reset values.
  localparam logic [15:0] DEST_RESET  = 16'h5001;
  localparam logic [7:0]  IDENT_RESET = 8'h01;
  localparam logic [7:0]  OPT_RESET   = 8'h00;

  // Configuration port.
  localparam int          PADDR_W   = 4;
  localparam logic [1:0]  REG_DEST  = 2'd0;
  localparam logic [1:0]  REG_IDENT = 2'd1;
  localparam logic [1:0]  REG_OPT   = 2'd2;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Byte positions of the back sequencer.
  localparam int          STEP_W         = 4;
  localparam logic [3:0]  STEP_SOF       = 4'd0;
  localparam logic [3:0]  STEP_LEN_HI    = 4'd1;
  localparam logic [3:0]  STEP_LEN_LO    = 4'd2;
  localparam logic [3:0]  STEP_API       = 4'd3;
  localparam logic [3:0]  STEP_IDENT     = 4'd4;
  localparam logic [3:0]  STEP_DEST_HI   = 4'd5;
  localparam logic [3:0]  STEP_DEST_LO   = 4'd6;
  localparam logic [3:0]  STEP_OPT       = 4'd7;
  localparam logic [3:0]  STEP_PAYLOAD   = 4'd8;
  localparam logic [3:0]  STEP_CHECKSUM  = 4'd9;

  // Live register values.
  typedef struct packed {
    logic [15:0] dest_address;
    logic [7:0]  frame_ident;
    logic [7:0]  tx_options;
  } cfg_t;

  // One classified item.
  typedef struct packed {
    logic       start;        // emit the header first
    logic [7:0] length;       // payload length, valid with start
    logic       has_payload;  // emit data_byte
    logic [7:0] data;
    logic       checksum;     // close the frame after this item
  } cmd_t;

endpackage

// ===== rtl/core/atfb_stream_if.sv =====
// ---------------------------------------------------------------------------
// atfb stream interfaces
// Valid/ready channels for input items and serialized frame bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_length;
  logic [7:0] data_byte;

  modport source(output valid, output payload_length, output data_byte, input ready);
  modport sink(input valid, input payload_length, input data_byte, output ready);
endinterface

interface atfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_of_run;
  logic       end_of_frame;

  modport source(output valid, output frame_byte, output last_of_run, output end_of_frame,
                 input ready);
  modport sink(input valid, input frame_byte, input last_of_run, input end_of_frame,
               output ready);
endinterface

// ===== rtl/core/atfb_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// atfb_cfg_regs
// APB register file: destination address, frame identifier, options.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module atfb_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [atfb_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output atfb_pkg::cfg_t                cfg
);

  logic [15:0] dest_r;
  logic [7:0]  ident_r;
  logic [7:0]  opt_r;
  logic        wr_en;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_r  <= atfb_pkg::DEST_RESET;
      ident_r <= atfb_pkg::IDENT_RESET;
      opt_r   <= atfb_pkg::OPT_RESET;
    end else if (wr_en) begin
      unique case (idx)
        atfb_pkg::REG_DEST:  dest_r  <= pwdata[15:0];
        atfb_pkg::REG_IDENT: ident_r <= pwdata[7:0];
        atfb_pkg::REG_OPT:   opt_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      atfb_pkg::REG_DEST:  prdata = {16'h0000, dest_r};
      atfb_pkg::REG_IDENT: prdata = {24'h000000, ident_r};
      atfb_pkg::REG_OPT:   prdata = {24'h000000, opt_r};
      default:             prdata = 32'h0000_0000;
    endcase
  end

  assign cfg.dest_address = dest_r;
  assign cfg.frame_ident  = ident_r;
  assign cfg.tx_options   = opt_r;

endmodule

// ===== rtl/core/atfb_front.sv =====
// ---------------------------------------------------------------------------
// atfb_front
// Accepts input items, tracks the frame and pushes one command per item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module atfb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      payload_length,
  input  logic [7:0]      data_byte,
  input  logic            q_full,
  output logic            q_push,
  output atfb_pkg::cmd_t  q_cmd
);

  logic       in_frame_r, in_frame_nxt;
  logic [7:0] remaining_r, remaining_nxt;
  logic [7:0] rem_eff;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classify the beat and compute the frame state after it.
  always_comb begin
    rem_eff       = (remaining_r == 8'd0) ? 8'd1 : remaining_r;
    q_cmd.data    = data_byte;
    q_cmd.length  = payload_length;
    q_cmd.start   = !in_frame_r;
    if (!in_frame_r) begin
      q_cmd.has_payload = (payload_length != 8'd0);
      q_cmd.checksum    = (payload_length <= 8'd1);
      in_frame_nxt      = (payload_length > 8'd1);
      remaining_nxt     = (payload_length == 8'd0) ? 8'd0 : payload_length - 8'd1;
    end else begin
      q_cmd.has_payload = 1'b1;
      q_cmd.checksum    = (rem_eff == 8'd1);
      in_frame_nxt      = (rem_eff != 8'd1);
      remaining_nxt     = rem_eff - 8'd1;
    end
  end

  // Frame tracking registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      remaining_r <= 8'd0;
    end else if (q_push) begin
      in_frame_r  <= in_frame_nxt;
      remaining_r <= remaining_nxt;
    end
  end

endmodule

// ===== rtl/core/atfb_queue.sv =====
// ---------------------------------------------------------------------------
// atfb_queue
// Small command FIFO that decouples the front from the byte sequencer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module atfb_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  atfb_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output atfb_pkg::cmd_t  head_cmd,
  output logic            full,
  output logic            empty
);

  atfb_pkg::cmd_t                 mem_r [atfb_pkg::QDEPTH];
  logic [atfb_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [atfb_pkg::QCNT_W-1:0]    count_r;

  assign full     = (count_r == atfb_pkg::QCNT_W'(atfb_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem_r[rd_ptr_r];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `ATFB_NEVER(a_no_overflow, clk, rst_n, push && full, "push into full command queue")
  `ATFB_NEVER(a_no_underflow, clk, rst_n, pop && empty, "pop from empty command queue")
  `ATFB_ASSERT(a_push_fills, clk, rst_n, (push && !pop) |=> !empty, "queue empty after push")

endmodule

// ===== rtl/core/atfb_back.sv =====
// ---------------------------------------------------------------------------
// atfb_back
// Byte sequencer: turns commands into frame bytes and keeps the checksum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module atfb_back (
  input  logic            clk,
  input  logic            rst_n,
  input  atfb_pkg::cfg_t  cfg,
  input  logic            q_empty,
  input  atfb_pkg::cmd_t  head_cmd,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      frame_byte,
  output logic            last_of_run,
  output logic            end_of_frame
);

  logic                          busy_r;
  logic [atfb_pkg::STEP_W-1:0]   step_r;
  logic [7:0]                    sum_r, sum_nxt;
  logic                          out_valid_r;
  logic [7:0]                    byte_r;
  logic                          last_r, eof_r;

  logic                          advance;
  logic [atfb_pkg::STEP_W-1:0]   step_cur, step_next;
  logic [8:0]                    total;
  logic [7:0]                    byte_cur;
  logic                          step_last;

  assign advance  = !q_empty && (!out_valid_r || out_ready);
  assign step_cur = busy_r ? step_r
                  : (head_cmd.start ? atfb_pkg::STEP_SOF : atfb_pkg::STEP_PAYLOAD);
  assign total    = {1'b0, head_cmd.length} + atfb_pkg::LEN_OVERHEAD;

  // Byte for the current step.
  always_comb begin
    unique case (step_cur)
      atfb_pkg::STEP_SOF:      byte_cur = atfb_pkg::FRAME_START;
      atfb_pkg::STEP_LEN_HI:   byte_cur = {7'b0, total[8]};
      atfb_pkg::STEP_LEN_LO:   byte_cur = total[7:0];
      atfb_pkg::STEP_API:      byte_cur = atfb_pkg::API_TX16;
      atfb_pkg::STEP_IDENT:    byte_cur = cfg.frame_ident;
      atfb_pkg::STEP_DEST_HI:  byte_cur = cfg.dest_address[15:8];
      atfb_pkg::STEP_DEST_LO:  byte_cur = cfg.dest_address[7:0];
      atfb_pkg::STEP_OPT:      byte_cur = cfg.tx_options;
      atfb_pkg::STEP_PAYLOAD:  byte_cur = head_cmd.data;
      atfb_pkg::STEP_CHECKSUM: byte_cur = ~sum_r;
      default:                 byte_cur = 8'h00;
    endcase
  end

  // Step sequencing and checksum accumulation.
  always_comb begin
    step_last = (step_cur == atfb_pkg::STEP_CHECKSUM)
             || (step_cur == atfb_pkg::STEP_PAYLOAD && !head_cmd.checksum);
    if (step_cur == atfb_pkg::STEP_OPT) begin
      step_next = head_cmd.has_payload ? atfb_pkg::STEP_PAYLOAD : atfb_pkg::STEP_CHECKSUM;
    end else begin
      step_next = step_cur + 1'b1;
    end
    if (step_cur == atfb_pkg::STEP_API) begin
      sum_nxt = atfb_pkg::API_TX16;
    end else if (step_cur >= atfb_pkg::STEP_IDENT && step_cur <= atfb_pkg::STEP_PAYLOAD) begin
      sum_nxt = sum_r + byte_cur;
    end else begin
      sum_nxt = sum_r;
    end
  end

  assign q_pop = advance && step_last;

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= atfb_pkg::STEP_SOF;
      sum_r  <= 8'h00;
    end else if (advance) begin
      busy_r <= !step_last;
      step_r <= step_next;
      sum_r  <= sum_nxt;
    end
  end

  // Output register: a beat waits here until it is taken; the sequencer stalls meanwhile.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      byte_r <= byte_cur;
      last_r <= step_last;
      eof_r  <= (step_cur == atfb_pkg::STEP_CHECKSUM);
    end
  end

  assign out_valid    = out_valid_r;
  assign frame_byte   = byte_r;
  assign last_of_run  = last_r;
  assign end_of_frame = eof_r;

  `ATFB_NEVER(a_step_range, clk, rst_n, busy_r && (step_r > atfb_pkg::STEP_CHECKSUM),
              "sequencer step out of range")
  `ATFB_ASSERT(a_eof_is_last, clk, rst_n, (out_valid_r && eof_r) |-> last_r,
               "checksum beat not flagged last of run")
  `ATFB_ASSERT(a_api_seeds_sum, clk, rst_n,
               (advance && step_cur == atfb_pkg::STEP_API) |=> (sum_r == atfb_pkg::API_TX16),
               "checksum not seeded at API id")

endmodule

// ===== rtl/core/api_tx_frame_builder.sv =====
// ---------------------------------------------------------------------------
// api_tx_frame_builder
// Wraps payload bytes into 16-bit-address API transmit request frames.
// ---------------------------------------------------------------------------
//
//   channel   dir   handshake        payload
//   in_ch     in    valid/ready      payload_length[7:0], data_byte[7:0]
//   out_ch    out   valid/ready      frame_byte[7:0], last_of_run, end_of_frame
//   cfg_*     in    APB, pready=1    dest_address, frame_ident, tx_options
//
// A frame's first item yields the header, any payload byte and the checksum if
// the frame ends; later items a payload byte, the last also the checksum. The
// byte sequencer emits one byte per cycle while the output is ready; a 4-entry
// command queue lets the input keep accepting while the header is going out.
// Reset (rst_n low, synchronous) empties the queue and output register and
// restores the register reset values. Output stalls back up into the queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module api_tx_frame_builder (
  input  logic                          clk,
  input  logic                          rst_n,
  atfb_in_if.sink                       in_ch,
  atfb_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [atfb_pkg::PADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  atfb_pkg::cfg_t cfg;
  atfb_pkg::cmd_t push_cmd;
  atfb_pkg::cmd_t head_cmd;
  logic           q_push, q_pop, q_full, q_empty;
  logic           in_ready;

  // Register file.
  atfb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Front: accept and classify.
  atfb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ready),
    .payload_length (in_ch.payload_length),
    .data_byte      (in_ch.data_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  assign in_ch.ready = in_ready;

  // Command queue.
  atfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: byte sequencer.
  atfb_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .head_cmd     (head_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .frame_byte   (out_ch.frame_byte),
    .last_of_run  (out_ch.last_of_run),
    .end_of_frame (out_ch.end_of_frame)
  );

endmodule

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// API transmit frame builder testbench
// Drives payload items into api_tx_frame_builder and checks every serialized
// frame beat against a cycle-free predictor of the frame format. A short
// directed table covers reset values, register extremes, mid-frame writes
// and the unused register slot. Randomized frames with random idling on both
// channels follow.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import atfb_pkg::*;

  localparam int          RANDOM_ITEMS = 395;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          TAIL_CYCLES  = 24;
  localparam logic [7:0]  REG_NONE     = 8'd3;

  // One expected output beat.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_run;
    logic       end_of_frame;
  } frame_beat_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_WRITE} row_kind_t;

  // Directed step: an item (length, data) or a register write (index, value).
  // Where the checksum is obvious it is typed in and replaces the predicted one.
  typedef struct {
    row_kind_t   kind;
    logic [7:0]  field_a;
    logic [31:0] field_b;
    bit          cs_known;
    logic [7:0]  cs_value;
  } stim_row_t;

  logic clk;
  logic rst_n;

  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [PADDR_W-1:0]   cfg_paddr;
  logic [31:0]          cfg_pwdata;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  atfb_in_if  in_bus ();
  atfb_out_if out_bus ();

  // Frame state of the predictor and its copy of the registers.
  bit          tx_active;
  logic [7:0]  bytes_left;
  logic [7:0]  csum_acc;
  logic [15:0] cfg_dest;
  logic [7:0]  cfg_ident;
  logic [7:0]  cfg_opt;

  frame_beat_t frame_beats[$];

  int errors;
  int items_sent;
  int frames_started;
  int beats_checked;
  int reg_writes;
  int snd_idle_pct;
  int rcv_idle_pct;

  stim_row_t directed_rows[21];

  api_tx_frame_builder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, counted in clock cycles.
  initial begin
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout after %0d cycles, %0d beats still expected", $time, cycles,
                 frame_beats.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Beat expectation helpers.
  function automatic void push_beat(input logic [7:0] b, input logic eof);
    frame_beat_t beat;
    beat.frame_byte   = b;
    beat.last_of_run  = 1'b0;
    beat.end_of_frame = eof;
    frame_beats.push_back(beat);
  endfunction

  function automatic void push_summed(input logic [7:0] b);
    csum_acc = csum_acc + b;
    push_beat(b, 1'b0);
  endfunction

  function automatic void push_payload(input logic [7:0] b);
    push_summed(b);
    bytes_left = bytes_left - 8'd1;
    if (bytes_left == 8'd0) begin
      push_beat(8'hFF - csum_acc, 1'b1);
      tx_active = 1'b0;
    end
  endfunction

  // Works out the beats that one accepted item produces.
  function automatic void predict_frame_bytes(input logic [7:0] len, input logic [7:0] data);
    logic [15:0] frame_len;
    frame_beat_t tail;
    if (!tx_active) begin
      frame_len = {8'h00, len} + {7'd0, LEN_OVERHEAD};
      csum_acc  = 8'h00;
      frames_started++;
      push_beat(FRAME_START, 1'b0);
      push_beat(frame_len[15:8], 1'b0);
      push_beat(frame_len[7:0], 1'b0);
      push_summed(API_TX16);
      push_summed(cfg_ident);
      push_summed(cfg_dest[15:8]);
      push_summed(cfg_dest[7:0]);
      push_summed(cfg_opt);
      if (len == 8'd0) begin
        push_beat(8'hFF - csum_acc, 1'b1);
        bytes_left = 8'd0;
      end else begin
        tx_active  = 1'b1;
        bytes_left = len;
        push_payload(data);
      end
    end else begin
      if (bytes_left == 8'd0) begin
        bytes_left = 8'd1;
      end
      push_payload(data);
    end
    tail = frame_beats.pop_back();
    tail.last_of_run = 1'b1;
    frame_beats.push_back(tail);
  endfunction

  // Sends one item after a random number of idle cycles.
  task automatic send_item(input logic [7:0] len, input logic [7:0] data);
    int gaps;
    gaps = 0;
    while (gaps < 20 && $urandom_range(99) < snd_idle_pct) begin
      gaps++;
    end
    repeat (gaps) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.payload_length <= len;
    in_bus.data_byte      <= data;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    items_sent++;
    predict_frame_bytes(len, data);
  endtask

  // Holds the input off until every expected beat has come out.
  task automatic settle_link();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (frame_beats.size() != 0);
  endtask

  // APB write of one register once the block has gone quiet.
  task automatic write_register(input logic [7:0] idx, input logic [31:0] value);
    settle_link();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    reg_writes++;
    case (idx)
      {6'd0, REG_DEST}:  cfg_dest  = value[15:0];
      {6'd0, REG_IDENT}: cfg_ident = value[7:0];
      {6'd0, REG_OPT}:   cfg_opt   = value[7:0];
      default: ;
    endcase
  endtask

  // Output side: random stalls and a field-by-field check of each beat.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin : rx_check
        frame_beat_t want;
        if (frame_beats.size() == 0) begin
          errors++;
          $display("%0t: beat with nothing expected, got byte %h last %b eof %b", $time,
                   out_bus.frame_byte, out_bus.last_of_run, out_bus.end_of_frame);
        end else begin
          want = frame_beats.pop_front();
          beats_checked++;
          if (out_bus.frame_byte !== want.frame_byte) begin
            errors++;
            $display("%0t: frame_byte expected %h actual %h", $time, want.frame_byte,
                     out_bus.frame_byte);
          end
          if (out_bus.last_of_run !== want.last_of_run) begin
            errors++;
            $display("%0t: last_of_run expected %b actual %b", $time, want.last_of_run,
                     out_bus.last_of_run);
          end
          if (out_bus.end_of_frame !== want.end_of_frame) begin
            errors++;
            $display("%0t: end_of_frame expected %b actual %b", $time, want.end_of_frame,
                     out_bus.end_of_frame);
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Stimulus: reset, directed table, then random frames in three idle mixes.
  initial begin
    stim_row_t   row;
    frame_beat_t tail;
    logic [7:0]  len;
    logic [7:0]  reg_idx;
    logic [31:0] reg_val;
    bit          long_done;
    int          pick;

    errors         = 0;
    items_sent     = 0;
    frames_started = 0;
    beats_checked  = 0;
    reg_writes     = 0;
    snd_idle_pct   = 36;
    rcv_idle_pct   = 77;
    long_done      = 1'b0;

    tx_active  = 1'b0;
    bytes_left = 8'd0;
    csum_acc   = 8'd0;
    cfg_dest   = DEST_RESET;
    cfg_ident  = IDENT_RESET;
    cfg_opt    = OPT_RESET;

    rst_n                 <= 1'b0;
    in_bus.valid          <= 1'b0;
    in_bus.payload_length <= 8'd0;
    in_bus.data_byte      <= 8'd0;
    cfg_psel              <= 1'b0;
    cfg_penable           <= 1'b0;
    cfg_pwrite            <= 1'b0;
    cfg_paddr             <= '0;
    cfg_pwdata            <= 32'd0;

    directed_rows = '{
      // Reset register values: empty frame, then one-byte frames at both extremes.
      '{ROW_ITEM,  8'h00, 32'h0000_00FF, 1'b1, 8'hAC},
      '{ROW_ITEM,  8'h01, 32'h0000_0000, 1'b1, 8'hAC},
      '{ROW_ITEM,  8'h01, 32'h0000_00FF, 1'b1, 8'hAD},
      // Three-byte frame; the length field of later items is ignored.
      '{ROW_ITEM,  8'h03, 32'h0000_0012, 1'b0, 8'h00},
      '{ROW_ITEM,  8'hFF, 32'h0000_0034, 1'b0, 8'h00},
      '{ROW_ITEM,  8'h00, 32'h0000_0056, 1'b0, 8'h00},
      // Register write while a frame is open.
      '{ROW_ITEM,  8'h02, 32'h0000_009A, 1'b0, 8'h00},
      '{ROW_WRITE, {6'd0, REG_IDENT}, 32'h0000_005A, 1'b0, 8'h00},
      '{ROW_ITEM,  8'h00, 32'h0000_00BC, 1'b0, 8'h00},
      // All registers at their maximum.
      '{ROW_WRITE, {6'd0, REG_DEST},  32'h0000_FFFF, 1'b0, 8'h00},
      '{ROW_WRITE, {6'd0, REG_IDENT}, 32'h0000_00FF, 1'b0, 8'h00},
      '{ROW_WRITE, {6'd0, REG_OPT},   32'h0000_00FF, 1'b0, 8'h00},
      '{ROW_ITEM,  8'h00, 32'h0000_0000, 1'b1, 8'h02},
      '{ROW_ITEM,  8'h01, 32'h0000_00FF, 1'b1, 8'h03},
      // All registers at zero.
      '{ROW_WRITE, {6'd0, REG_DEST},  32'h0000_0000, 1'b0, 8'h00},
      '{ROW_WRITE, {6'd0, REG_IDENT}, 32'h0000_0000, 1'b0, 8'h00},
      '{ROW_WRITE, {6'd0, REG_OPT},   32'h0000_0000, 1'b0, 8'h00},
      '{ROW_ITEM,  8'h00, 32'h0000_0055, 1'b1, 8'hFE},
      // A write to the unused slot must change nothing.
      '{ROW_WRITE, REG_NONE, 32'hFFFF_FFFF, 1'b0, 8'h00},
      '{ROW_ITEM,  8'h00, 32'h0000_00AA, 1'b1, 8'hFE},
      '{ROW_WRITE, {6'd0, REG_DEST}, {16'h0000, DEST_RESET}, 1'b0, 8'h00}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        write_register(row.field_a, row.field_b);
      end else begin
        send_item(row.field_a, row.field_b[7:0]);
        if (row.cs_known) begin
          tail = frame_beats.pop_back();
          tail.frame_byte = row.cs_value;
          frame_beats.push_back(tail);
        end
      end
    end

    // Random frames; mostly short, one at the maximum length.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n < RANDOM_ITEMS / 3) begin
        snd_idle_pct = 36;
        rcv_idle_pct = 77;
      end else if (n < 2 * RANDOM_ITEMS / 3) begin
        snd_idle_pct = 77;
        rcv_idle_pct = 36;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end

      // Now and then let the block drain, sometimes with a register write.
      pick = $urandom_range(99);
      if (pick < 2) begin
        settle_link();
      end else if (pick < 5) begin
        case ($urandom_range(3))
          0: reg_idx = {6'd0, REG_DEST};
          1: reg_idx = {6'd0, REG_IDENT};
          2: reg_idx = {6'd0, REG_OPT};
          default: reg_idx = REG_NONE;
        endcase
        case ($urandom_range(3))
          0: reg_val = 32'h0000_0000;
          1: reg_val = 32'hFFFF_FFFF;
          default: reg_val = $urandom;
        endcase
        write_register(reg_idx, reg_val);
      end

      len = 8'($urandom_range(255));
      if (!tx_active) begin
        if (!long_done && n >= 20) begin
          len       = 8'd255;
          long_done = 1'b1;
        end else begin
          pick = $urandom_range(99);
          if (pick < 15) begin
            len = 8'd0;
          end else if (pick < 30) begin
            len = 8'd1;
          end else if (pick < 85) begin
            len = 8'($urandom_range(8, 2));
          end else begin
            len = 8'($urandom_range(40, 9));
          end
        end
      end
      send_item(len, 8'($urandom_range(255)));
    end

    // Drain and let the pipeline settle.
    settle_link();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (frame_beats.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, frame_beats.size());
    end

    $display("Sent %0d items in %0d frames (up to 255 payload bytes), checked %0d beats.",
             items_sent, frames_started, beats_checked);
    $display("Made %0d register writes under three stall mixes; %0d mismatches.",
             reg_writes, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== api_tx_frame_builder.f =====
+incdir+rtl/core
rtl/core/atfb_pkg.sv
rtl/core/atfb_stream_if.sv
rtl/core/atfb_cfg_regs.sv
rtl/core/atfb_front.sv
rtl/core/atfb_queue.sv
rtl/core/atfb_back.sv
rtl/core/api_tx_frame_builder.sv
verif/testbench.sv
